>>> hdl/avm_pkg.sv
// ----------------------------------------------------------------------------
// avm_pkg: shared definitions for the autoranging voltmeter scaler
// Register indexes, sequencer states and fixed widths.
// ----------------------------------------------------------------------------
package avm_pkg;

  localparam int ADC_BITS_DEF = 24;   // default ADC word width
  localparam int DIV_W        = 32;   // slope and divisor width
  localparam int UV_W         = 31;   // microvolt result width
  localparam int ERR_W        = 8;
  localparam int CNT_W        = 32;
  localparam int VAL_W        = 42;   // signed scaled value before clamping
  localparam int QLIM_LOG2    = 40;   // quotient magnitude limit is 2**40

  localparam logic [UV_W-1:0]  UV_MAX      = '1;
  localparam logic [DIV_W-1:0] DIVISOR_RST = 32'd1;

  typedef enum logic [2:0] {
    REG_SLOPE_HI  = 3'd0,
    REG_OFFSET_HI = 3'd1,
    REG_SLOPE_LO  = 3'd2,
    REG_OFFSET_LO = 3'd3,
    REG_DIVISOR   = 3'd4,
    REG_THR_UP    = 3'd5,
    REG_THR_DOWN  = 3'd6,
    REG_MIN_VOLT  = 3'd7
  } avm_reg_e;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_MUL  = 5'b00010,
    ST_DIV  = 5'b00100,
    ST_FIN  = 5'b01000,
    ST_DONE = 5'b10000
  } state_t;

  // Bit positions of the result fields in out_tdata
  localparam int OUT_RANGE_BIT = 2 * UV_W;
  localparam int OUT_W         = 2 * UV_W + 1 + ERR_W + 1 + CNT_W;

endpackage

>>> hdl/autoranging_voltmeter_scaler.sv
// ----------------------------------------------------------------------------
// autoranging_voltmeter_scaler: two-range voltmeter scaling with hysteresis
// Each reading runs a serial multiply/divide for the filtered, then unfiltered
// sample, or is skipped; a new reading is taken only once the last one is out.
// rst_n (synchronous, low) selects the high range, clears counts and voltages.
// ----------------------------------------------------------------------------
module autoranging_voltmeter_scaler #(
  parameter int ADC_BITS = avm_pkg::ADC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // configuration write channel
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [2:0]                          cfg_index,
  input  logic [avm_pkg::DIV_W-1:0]           cfg_data,
  // input stream
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // in_tdata, low bit up: raw_filtered, raw_unfiltered, new_overload, cv_mode
  input  logic [((2*ADC_BITS+2+7)/8)*8-1:0]   in_tdata,
  // result stream
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // out_tdata, low bit up: voltage_uv, unfiltered_uv, range_now, error_total,
  // error_kind, reading_count
  output logic [avm_pkg::OUT_W-1:0]           out_tdata,
  // out_tuser: updated
  output logic                                out_tuser
);

  import avm_pkg::*;

  // Product/dividend register width and step counter width
  localparam int PW = DIV_W + ADC_BITS;
  localparam int CW = $clog2(PW);
  localparam logic [PW-1:0] QLIM = PW'(1) << QLIM_LOG2;

  // --------------------------------------------------------------------------
  // Configuration registers. Writes are accepted in every cycle; the caller must
  // only write while no reading is in flight, the block itself does not enforce it.
  // --------------------------------------------------------------------------
  logic [DIV_W-1:0] slope_hi_r, slope_hi_nxt, slope_lo_r, slope_lo_nxt;
  logic [DIV_W-1:0] off_hi_r, off_hi_nxt, off_lo_r, off_lo_nxt;
  logic [DIV_W-1:0] divisor_r, divisor_nxt, min_volt_r, min_volt_nxt;
  logic [UV_W-1:0]  thr_up_r, thr_up_nxt, thr_dn_r, thr_dn_nxt;

  assign cfg_ready = 1'b1;

  always_comb begin
    slope_hi_nxt = slope_hi_r;
    slope_lo_nxt = slope_lo_r;
    off_hi_nxt   = off_hi_r;
    off_lo_nxt   = off_lo_r;
    divisor_nxt  = divisor_r;
    min_volt_nxt = min_volt_r;
    thr_up_nxt   = thr_up_r;
    thr_dn_nxt   = thr_dn_r;
    if (cfg_valid) begin
      unique case (avm_reg_e'(cfg_index))
        REG_SLOPE_HI:  slope_hi_nxt = cfg_data;
        REG_OFFSET_HI: off_hi_nxt   = cfg_data;
        REG_SLOPE_LO:  slope_lo_nxt = cfg_data;
        REG_OFFSET_LO: off_lo_nxt   = cfg_data;
        REG_DIVISOR:   divisor_nxt  = cfg_data;
        REG_THR_UP:    thr_up_nxt   = cfg_data[UV_W-1:0];
        REG_THR_DOWN:  thr_dn_nxt   = cfg_data[UV_W-1:0];
        REG_MIN_VOLT:  min_volt_nxt = cfg_data;
        default:       min_volt_nxt = min_volt_r;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Meter state. These registers also drive the result port directly: all but
  // out_valid_r change only at the edge that presents a new result.
  // --------------------------------------------------------------------------
  logic              range_r, range_nxt;
  logic [ERR_W-1:0]  err_r, err_nxt;
  logic              last_r, last_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [UV_W-1:0]   held_v_r, held_v_nxt, held_u_r, held_u_nxt;
  logic              upd_r, upd_nxt;
  logic              out_valid_r, out_valid_nxt;

  // Sequencer and shared datapath
  state_t             state_r, state_nxt;
  logic               sel_r, sel_nxt;        // 0 filtered, 1 unfiltered
  logic [CW-1:0]      cnt_r, cnt_nxt;
  logic [PW-1:0]      prod_r, prod_nxt;      // product, then dividend/quotient
  logic [DIV_W-1:0]   rem_r, rem_nxt;
  logic [ADC_BITS-1:0] raw_f_r, raw_f_nxt, raw_u_r, raw_u_nxt;
  logic               ovl_r, ovl_nxt, cv_r, cv_nxt;
  logic signed [VAL_W-1:0] vf_r, vf_nxt, vu_r, vu_nxt;

  // Magnitude of a two's complement ADC word
  function automatic logic [ADC_BITS-1:0] mag_of(input logic [ADC_BITS-1:0] x);
    mag_of = x[ADC_BITS-1] ? ADC_BITS'(~x + 1'b1) : x;
  endfunction

  // Clamp a signed scaled value to the unsigned microvolt range
  function automatic logic [UV_W-1:0] clamp_uv(input logic signed [VAL_W-1:0] v);
    if (v[VAL_W-1]) begin
      clamp_uv = '0;
    end else if (v[VAL_W-2:UV_W] != '0) begin
      clamp_uv = UV_MAX;
    end else begin
      clamp_uv = v[UV_W-1:0];
    end
  endfunction

  // Range dependent coefficients; the range selection stays fixed while a reading is in work
  logic [DIV_W-1:0] slope, offset, div_eff;
  assign slope   = range_r ? slope_hi_r : slope_lo_r;
  assign offset  = range_r ? off_hi_r : off_lo_r;
  assign div_eff = (divisor_r == '0) ? DIVISOR_RST : divisor_r;

  // --------------------------------------------------------------------------
  // Shared 33-bit add/subtract unit: adds the slope during the shift-add
  // multiply, subtracts the divisor during the restoring divide.
  // --------------------------------------------------------------------------
  logic [DIV_W:0]   alu_a, alu_b;
  logic             alu_sub;
  logic [DIV_W+1:0] alu_res;

  always_comb begin
    alu_sub = state_r == ST_DIV;
    if (alu_sub) begin
      alu_a = {rem_r, prod_r[PW-1]};
      alu_b = {1'b0, div_eff};
    end else begin
      alu_a = {1'b0, prod_r[PW-1:ADC_BITS]};
      alu_b = prod_r[0] ? {1'b0, slope} : '0;
    end
    alu_res = alu_sub ? ({1'b0, alu_a} - {1'b0, alu_b})
                      : ({1'b0, alu_a} + {1'b0, alu_b});
  end

  // Quotient limit, sign and offset of the reading just divided
  logic [QLIM_LOG2:0]      q_lim;
  logic signed [VAL_W-1:0] q_signed, v_cur;
  logic [ADC_BITS-1:0]     raw_cur;

  always_comb begin
    raw_cur  = sel_r ? raw_u_r : raw_f_r;
    q_lim    = (prod_r > QLIM) ? QLIM[QLIM_LOG2:0] : prod_r[QLIM_LOG2:0];
    q_signed = raw_cur[ADC_BITS-1] ? -$signed({1'b0, q_lim}) : $signed({1'b0, q_lim});
    v_cur    = q_signed + $signed({{(VAL_W-DIV_W){offset[DIV_W-1]}}, offset});
  end

  // Result bookkeeping, evaluated in the final state
  logic              skip;
  logic [UV_W-1:0]   new_v, new_u;
  logic              below_min;
  logic [ERR_W-1:0]  err_add;

  always_comb begin
    skip      = !range_r && ovl_r && !cv_r;
    new_v     = clamp_uv(vf_r);
    new_u     = clamp_uv(vu_r);
    below_min = vu_r < $signed({{(VAL_W-DIV_W){min_volt_r[DIV_W-1]}}, min_volt_r});
    err_add   = ERR_W'(range_r && ovl_r) + ERR_W'(below_min);
  end

  assign in_tready = state_r == ST_IDLE;

  // --------------------------------------------------------------------------
  // Sequencer: per reading ADC_BITS multiply steps, PW divide steps and one
  // step for limit, sign and offset; filtered first, then unfiltered.
  // --------------------------------------------------------------------------
  always_comb begin
    state_nxt     = state_r;
    sel_nxt       = sel_r;
    cnt_nxt       = cnt_r;
    prod_nxt      = prod_r;
    rem_nxt       = rem_r;
    raw_f_nxt     = raw_f_r;
    raw_u_nxt     = raw_u_r;
    ovl_nxt       = ovl_r;
    cv_nxt        = cv_r;
    vf_nxt        = vf_r;
    vu_nxt        = vu_r;
    range_nxt     = range_r;
    err_nxt       = err_r;
    last_nxt      = last_r;
    count_nxt     = count_r;
    held_v_nxt    = held_v_r;
    held_u_nxt    = held_u_r;
    upd_nxt       = upd_r;
    out_valid_nxt = out_valid_r && !out_tready;

    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          raw_f_nxt = in_tdata[ADC_BITS-1:0];
          raw_u_nxt = in_tdata[2*ADC_BITS-1:ADC_BITS];
          ovl_nxt   = in_tdata[2*ADC_BITS];
          cv_nxt    = in_tdata[2*ADC_BITS+1];
          sel_nxt   = 1'b0;
          cnt_nxt   = '0;
          prod_nxt  = {{DIV_W{1'b0}}, mag_of(in_tdata[ADC_BITS-1:0])};
          // Overload in the low range outside CV mode: no scaling at all
          if (!range_r && in_tdata[2*ADC_BITS] && !in_tdata[2*ADC_BITS+1]) begin
            state_nxt = ST_DONE;
          end else begin
            state_nxt = ST_MUL;
          end
        end
      end
      ST_MUL: begin
        prod_nxt = {alu_res[DIV_W:0], prod_r[ADC_BITS-1:1]};
        if (cnt_r == CW'(ADC_BITS - 1)) begin
          cnt_nxt   = '0;
          rem_nxt   = '0;
          state_nxt = ST_DIV;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_DIV: begin
        // Borrow clear means the shifted remainder covers the divisor
        if (!alu_res[DIV_W+1]) begin
          rem_nxt  = alu_res[DIV_W-1:0];
          prod_nxt = {prod_r[PW-2:0], 1'b1};
        end else begin
          rem_nxt  = alu_a[DIV_W-1:0];
          prod_nxt = {prod_r[PW-2:0], 1'b0};
        end
        if (cnt_r == CW'(PW - 1)) begin
          state_nxt = ST_FIN;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_FIN: begin
        if (!sel_r) begin
          vf_nxt    = v_cur;
          sel_nxt   = 1'b1;
          cnt_nxt   = '0;
          prod_nxt  = {{DIV_W{1'b0}}, mag_of(raw_u_r)};
          state_nxt = ST_MUL;
        end else begin
          vu_nxt    = v_cur;
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        // Hold the result here until the output slot is free
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
          if (skip) begin
            range_nxt = 1'b1;
            upd_nxt   = 1'b0;
          end else begin
            upd_nxt    = 1'b1;
            err_nxt    = err_r + err_add;
            if (below_min) begin
              last_nxt = 1'b1;
            end else if (range_r && ovl_r) begin
              last_nxt = 1'b0;
            end
            held_v_nxt = new_v;
            held_u_nxt = new_u;
            count_nxt  = count_r + 1'b1;
            if (!cv_r) begin
              priority if (new_u > thr_up_r) begin
                range_nxt = 1'b1;
              end else if (new_u < thr_dn_r) begin
                range_nxt = 1'b0;
              end
            end
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control, configuration and meter state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      slope_hi_r  <= '0;
      slope_lo_r  <= '0;
      off_hi_r    <= '0;
      off_lo_r    <= '0;
      divisor_r   <= DIVISOR_RST;
      min_volt_r  <= '0;
      thr_up_r    <= '0;
      thr_dn_r    <= '0;
      range_r     <= 1'b1;
      err_r       <= '0;
      last_r      <= 1'b0;
      count_r     <= '0;
      held_v_r    <= '0;
      held_u_r    <= '0;
      upd_r       <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      slope_hi_r  <= slope_hi_nxt;
      slope_lo_r  <= slope_lo_nxt;
      off_hi_r    <= off_hi_nxt;
      off_lo_r    <= off_lo_nxt;
      divisor_r   <= divisor_nxt;
      min_volt_r  <= min_volt_nxt;
      thr_up_r    <= thr_up_nxt;
      thr_dn_r    <= thr_dn_nxt;
      range_r     <= range_nxt;
      err_r       <= err_nxt;
      last_r      <= last_nxt;
      count_r     <= count_nxt;
      held_v_r    <= held_v_nxt;
      held_u_r    <= held_u_nxt;
      upd_r       <= upd_nxt;
    end
  end

  // Datapath registers: meaningful only while the sequencer uses them
  always_ff @(posedge clk) begin
    sel_r   <= sel_nxt;
    cnt_r   <= cnt_nxt;
    prod_r  <= prod_nxt;
    rem_r   <= rem_nxt;
    raw_f_r <= raw_f_nxt;
    raw_u_r <= raw_u_nxt;
    ovl_r   <= ovl_nxt;
    cv_r    <= cv_nxt;
    vf_r    <= vf_nxt;
    vu_r    <= vu_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = upd_r;
  assign out_tdata  = {count_r, last_r, err_r, range_r, held_u_r, held_v_r};

endmodule

>>> hdl/avm_checker.sv
// ----------------------------------------------------------------------------
// avm_checker: port-level checks for the autoranging voltmeter scaler
// Watches the stream ports and flags sequencing and result slips.
// ----------------------------------------------------------------------------
module avm_checker #(
  parameter int ADC_BITS = avm_pkg::ADC_BITS_DEF
) (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_tvalid,
  input logic                              in_tready,
  input logic [((2*ADC_BITS+2+7)/8)*8-1:0] in_tdata,
  input logic                              out_tvalid,
  input logic                              out_tready,
  input logic [avm_pkg::OUT_W-1:0]         out_tdata,
  input logic                              out_tuser
);

  import avm_pkg::*;

  // One reading at a time: the input closes right after a transfer
  a_in_closes: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input still ready after a transfer");

  // Handshake outputs and the result word never go unknown
  a_known: assert property (@(posedge clk) disable iff (!rst_n)
    !$isunknown({in_tready, out_tvalid, out_tuser, out_tdata}))
    else $error("unknown value on an output port");

  // A skipped update always leaves the meter in the high range
  a_skip_high: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser) |-> out_tdata[OUT_RANGE_BIT])
    else $error("skipped update outside the high range");

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)
                                     && $stable(out_tuser)))
    else $error("stalled result changed");

endmodule

bind autoranging_voltmeter_scaler avm_checker #(.ADC_BITS(ADC_BITS)) u_avm_checker (.*);
